@@ src/sch_pkg.sv @@
// shared types and constants for the spatial cell hash table
package sch_pkg;

	// coordinate and result field widths
	localparam int COORD_W = 32;
	localparam int KEY_W   = 3 * COORD_W;
	localparam int SLOT_W  = 10;
	localparam int CNT_W   = 16;
	localparam int OCC_W   = 11;
	localparam int SIZE_W  = 4;

	// configuration port
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;
	localparam logic [APB_AW-1:0] ADDR_SIZE_LOG2 = 3'd0;
	localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd10;
	localparam logic [SIZE_W-1:0] MIN_LOG2 = 4'd4;

	// spatial hash primes
	localparam logic [31:0] HASH_PX = 32'd73856093;
	localparam logic [31:0] HASH_PY = 32'd19349663;
	localparam logic [31:0] HASH_PZ = 32'd83492791;

	// operation codes
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	// source of the result item
	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_PROBE = 2'd1,
		RES_FULL  = 2'd2
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic total_clr;
		logic hash_load;
		logic probe_next;
		logic clr_step;
		logic write_slot;
		logic insert;
		logic load_result;
		res_t kind;
	} sch_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic used;
		logic match;
		logic last_probe;
		logic clr_last;
	} sch_sts_t;

endpackage

@@ src/spatial_cell_hash_table.sv @@
// top level: configuration register, controller and datapath
// insert or lookup: hash, then a ram read and a key check for each slot probed, then the result
// one item in flight: no new item is accepted until the last result is loaded; one ram read per probe
// clear walks every slot, one per cycle, then gives its result
// unused operation codes skip the probe and give a zero result
// after reset a clearing pass over every slot runs with in_ready low;
// configuration writes are taken throughout, size_log2 resets to 10
module spatial_cell_hash_table import sch_pkg::*; #(
	parameter int TABLE_SLOTS = 1024,
	parameter int COUNT_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// apb configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_AW-1:0]         paddr,
	input  logic [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]         prdata,
	output logic                      pready,
	// input items
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                operation,
	input  logic signed [COORD_W-1:0] cell_x,
	input  logic signed [COORD_W-1:0] cell_y,
	input  logic signed [COORD_W-1:0] cell_z,
	// result items
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [SLOT_W-1:0]         slot_index,
	output logic                      found,
	output logic [CNT_W-1:0]          cell_count,
	output logic                      table_full,
	output logic [OCC_W-1:0]          occupied_cells
);

	logic [SIZE_W-1:0] size_log2_q;
	logic              cfg_wr;
	sch_cmd_t          cmd;
	sch_sts_t          sts;

	// size register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_SIZE_LOG2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= SIZE_LOG2_RESET;
		end else if (cfg_wr) begin
			size_log2_q <= pwdata[SIZE_W-1:0];
		end
	end

	// register read back
	assign prdata = (paddr == ADDR_SIZE_LOG2) ? APB_DW'(size_log2_q) : '0;

	sch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sch_dp #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.cell_z        (cell_z),
		.size_log2     (size_log2_q),
		.slot_index    (slot_index),
		.found         (found),
		.cell_count    (cell_count),
		.table_full    (table_full),
		.occupied_cells(occupied_cells)
	);

endmodule

@@ src/sch_ram.sv @@
// generic single write port, single read port ram with registered read
module sch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/sch_dp.sv @@
// datapath: key capture, hash, probe address, slot store and result register
module sch_dp import sch_pkg::*; #(
	parameter int TABLE_SLOTS = 1024,
	parameter int COUNT_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sch_cmd_t           cmd,
	output sch_sts_t           sts,
	input  logic [COORD_W-1:0] cell_x,
	input  logic [COORD_W-1:0] cell_y,
	input  logic [COORD_W-1:0] cell_z,
	input  logic [SIZE_W-1:0]  size_log2,
	output logic [SLOT_W-1:0]  slot_index,
	output logic               found,
	output logic [CNT_W-1:0]   cell_count,
	output logic               table_full,
	output logic [OCC_W-1:0]   occupied_cells
);

	localparam int AW  = $clog2(TABLE_SLOTS);
	localparam int TW  = AW + 1;
	localparam int CB  = COUNT_BITS;
	localparam int EW  = 1 + KEY_W + CB;
	localparam logic [4:0] AW5 = 5'(AW);
	localparam logic [AW-1:0] PX_LO = HASH_PX[AW-1:0];
	localparam logic [AW-1:0] PY_LO = HASH_PY[AW-1:0];
	localparam logic [AW-1:0] PZ_LO = HASH_PZ[AW-1:0];
	localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
	localparam logic [CB-1:0] CNT_ONE = CB'(1);

	logic [COORD_W-1:0] kx_q, ky_q, kz_q;
	logic [AW-1:0]      probe_q, steps_q, clr_q;
	logic [TW-1:0]      total_q;
	logic [4:0]         lg;
	logic [AW-1:0]      mask;
	logic [AW-1:0]      hx, hy, hz, home;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [EW-1:0]      ram_wdata, rd_data;
	logic               rd_used;
	logic [KEY_W-1:0]   rd_key;
	logic [CB-1:0]      rd_count, cnt_inc, cnt_new;
	logic               key_match;
	logic [TW-1:0]      total_next;

	// active size clamped to the supported range, then the slot mask
	always_comb begin
		if (size_log2 < MIN_LOG2) begin
			lg = 5'(MIN_LOG2);
		end else if (5'(size_log2) > AW5) begin
			lg = AW5;
		end else begin
			lg = 5'(size_log2);
		end
	end
	assign mask = {AW{1'b1}} >> (AW5 - lg);

	// home slot: only the low index bits of each product matter
	assign hx   = kx_q[AW-1:0] * PX_LO;
	assign hy   = ky_q[AW-1:0] * PY_LO;
	assign hz   = kz_q[AW-1:0] * PZ_LO;
	assign home = (hx ^ hy ^ hz) & mask;

	// fields of the slot just read
	assign rd_used   = rd_data[EW-1];
	assign rd_key    = rd_data[EW-2 -: KEY_W];
	assign rd_count  = rd_data[CB-1:0];
	assign key_match = (rd_key == {kx_q, ky_q, kz_q});
	assign cnt_inc   = (rd_count == CNT_MAX) ? rd_count : rd_count + CNT_ONE;
	assign cnt_new   = rd_used ? cnt_inc : CNT_ONE;

	assign sts.used       = rd_used;
	assign sts.match      = key_match;
	assign sts.last_probe = (steps_q == mask);
	assign sts.clr_last   = (clr_q == {AW{1'b1}});

	// write port: clearing sweep or slot update
	assign ram_we    = cmd.clr_step | cmd.write_slot;
	assign ram_waddr = cmd.clr_step ? clr_q : probe_q;
	assign ram_wdata = cmd.clr_step ? '0 : {1'b1, kx_q, ky_q, kz_q, cnt_new};

	sch_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(probe_q),
		.rdata(rd_data)
	);

	// occupancy after this item
	assign total_next = (cmd.write_slot && !rd_used) ? total_q + TW'(1) : total_q;

	// key capture and probe walk
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			kx_q <= cell_x;
			ky_q <= cell_y;
			kz_q <= cell_z;
		end
		if (cmd.hash_load) begin
			probe_q <= home;
			steps_q <= '0;
		end else if (cmd.probe_next) begin
			probe_q <= (probe_q + AW'(1)) & mask;
			steps_q <= steps_q + AW'(1);
		end
	end

	// sweep address and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.total_clr) begin
				total_q <= '0;
			end else begin
				total_q <= total_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			unique case (cmd.kind)
				RES_PROBE: begin
					if (rd_used || cmd.insert) begin
						slot_index <= SLOT_W'(probe_q);
					end else begin
						slot_index <= '0;
					end
					found <= rd_used;
					if (cmd.insert) begin
						cell_count <= CNT_W'(cnt_new);
					end else if (rd_used) begin
						cell_count <= CNT_W'(rd_count);
					end else begin
						cell_count <= '0;
					end
					table_full <= 1'b0;
				end
				RES_FULL: begin
					slot_index <= '0;
					found      <= 1'b0;
					cell_count <= '0;
					table_full <= 1'b1;
				end
				default: begin
					slot_index <= '0;
					found      <= 1'b0;
					cell_count <= '0;
					table_full <= 1'b0;
				end
			endcase
			occupied_cells <= OCC_W'(total_next);
		end
	end

	// slot updates only land on a free slot or the matching cell
	a_write_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_slot |-> (!rd_used || key_match))
		else $error("slot write on a foreign occupied slot");

	// occupancy can never pass the table size
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(TABLE_SLOTS))
		else $error("occupied count beyond table size");

	// a slot is written only as the item's result is taken into the output register
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_slot |-> (cmd.load_result && cmd.kind == RES_PROBE))
		else $error("slot write without result");

endmodule

@@ src/sch_ctrl.sv @@
// controller: clearing sweep, probe sequencing and output handshake
module sch_ctrl import sch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	output logic        out_valid,
	input  logic        out_ready,
	output sch_cmd_t    cmd,
	input  sch_sts_t    sts
);

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   reply_q;
	logic   insert_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	logic   hit;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign hit       = !sts.used || sts.match;

	// commands to the datapath
	always_comb begin
		cmd        = '0;
		cmd.kind   = RES_ZERO;
		cmd.insert = insert_q;
		unique case (state_q)
			S_SWEEP: begin
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				cmd.latch_in  = accept;
				cmd.total_clr = accept && (operation == OP_CLEAR);
			end
			S_HASH: begin
				cmd.hash_load = 1'b1;
			end
			S_READ: begin
			end
			S_CHECK: begin
				if (hit) begin
					cmd.load_result = out_free;
					cmd.kind        = RES_PROBE;
					cmd.write_slot  = out_free && insert_q;
				end else if (sts.last_probe) begin
					cmd.load_result = out_free;
					cmd.kind        = RES_FULL;
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			S_FINISH: begin
				cmd.load_result = out_free;
			end
			default: begin
			end
		endcase
	end

	// state, item flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			reply_q     <= 1'b0;
			insert_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (sts.clr_last) begin
						state_q <= reply_q ? S_FINISH : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						insert_q <= (operation == OP_INSERT);
						if (operation == OP_CLEAR) begin
							reply_q <= 1'b1;
							state_q <= S_SWEEP;
						end else if (operation == OP_INSERT || operation == OP_LOOKUP) begin
							state_q <= S_HASH;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_HASH: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (cmd.load_result) begin
						state_q <= S_IDLE;
					end else if (cmd.probe_next) begin
						state_q <= S_READ;
					end
				end
				S_FINISH: begin
					if (cmd.load_result) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// one item in flight: an accepted item drops ready
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second item accepted while busy");

	// a result never overwrites one that has not been taken
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> out_free)
		else $error("result loaded over a waiting result");

	// sweeping never overlaps a slot update
	a_sweep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !cmd.write_slot && !cmd.load_result)
		else $error("sweep overlaps slot update");

endmodule
